// ===== src/c2s_pkg.sv =====
// Shared types, constants and the month table for the calendar to seconds pipeline.
`default_nettype none

package c2s_pkg;

	// Field widths
	localparam int YEAR_W   = 7;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int DAYS_W   = 16;	// day count up to 36524
	localparam int TOD_W    = 17;	// time of day up to 86399
	localparam int SECS_W   = 32;
	localparam int MSTART_W = 9;	// cumulative month start up to 335

	// Range limits
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 7'd99;
	localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
	localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
	localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
	localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;

	// Scale factors
	localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 16'd365;
	localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 17'd3600;
	localparam logic [TOD_W-1:0]  SECS_PER_MIN  = 17'd60;
	localparam logic [SECS_W-1:0] SECS_PER_DAY  = 32'd86400;
	localparam logic [SECS_W-1:0] SECS_LIMIT    = 32'd3155760000;

	// Stage 1 payload: day count and time of day
	typedef struct packed {
		logic [DAYS_W-1:0] days;
		logic [TOD_W-1:0]  tod;
		logic              invalid;
	} days_t;

	// Stage 2 payload: scaled day count and time of day
	typedef struct packed {
		logic [SECS_W-1:0] day_secs;
		logic [TOD_W-1:0]  tod;
		logic              invalid;
	} scaled_t;

	// Days before the first of the month, February counted as 29 days
	function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
		logic [MSTART_W-1:0] r;
		case (idx)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd60;
			4'd3:    r = 9'd91;
			4'd4:    r = 9'd121;
			4'd5:    r = 9'd152;
			4'd6:    r = 9'd182;
			4'd7:    r = 9'd213;
			4'd8:    r = 9'd244;
			4'd9:    r = 9'd274;
			4'd10:   r = 9'd305;
			4'd11:   r = 9'd335;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/c2s_days.sv =====
// First pipeline stage: range check, day count and time of day.
`default_nettype none

module c2s_days (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_in,
	output logic                               ready_up,
	input  wire logic                          ready_dn,
	input  wire logic [c2s_pkg::YEAR_W-1:0]    year_since_2000,
	input  wire logic [c2s_pkg::MONTH_W-1:0]   month,
	input  wire logic [c2s_pkg::DAY_W-1:0]     day_of_month,
	input  wire logic [c2s_pkg::HOUR_W-1:0]    hour,
	input  wire logic [c2s_pkg::MIN_W-1:0]     minute,
	input  wire logic [c2s_pkg::SEC_W-1:0]     second,
	output logic                               vld_s1,
	output c2s_pkg::days_t                     data_s1
);
	import c2s_pkg::*;

	logic              bad;
	logic              leap;
	logic [DAYS_W-1:0] leap_days;
	logic [DAYS_W-1:0] days;
	logic [TOD_W-1:0]  tod;
	days_t             nxt;

	// Range check
	assign bad = (year_since_2000 > YEAR_MAX) || (month < MONTH_MIN) ||
		(month > MONTH_MAX) || (day_of_month < DAY_MIN) || (hour > HOUR_MAX) ||
		(minute > MIN_MAX) || (second > SEC_MAX);

	// Within 2000..2099 every fourth year is a leap year, 2000 included
	assign leap      = (year_since_2000[1:0] == 2'b00);
	assign leap_days = DAYS_W'((8'(year_since_2000) + 8'd3) >> 2);

	// Day count since 2000-01-01
	always_comb begin
		days = DAYS_W'(year_since_2000) * DAYS_PER_YEAR + leap_days +
			DAYS_W'(month_start(month - 4'd1));
		if (!leap && (month > MONTH_FEB)) begin
			days = days - 16'd1;
		end
		days = days + DAYS_W'(day_of_month) - 16'd1;
	end

	// Seconds into the day
	assign tod = TOD_W'(hour) * SECS_PER_HOUR + TOD_W'(minute) * SECS_PER_MIN +
		TOD_W'(second);

	always_comb begin
		nxt.days    = days;
		nxt.tod     = tod;
		nxt.invalid = bad;
	end

	// Stage advances when empty or when the next stage takes its item
	assign ready_up = !vld_s1 || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready_up) begin
			vld_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_in) begin
			data_s1 <= nxt;
		end
	end

	// A held item stays put while downstream is blocked
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !ready_dn |=> vld_s1 && $stable(data_s1))
		else $error("stage 1 item changed while blocked");

	// A loaded day count of a valid item stays at or below 36554
	a_days_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !data_s1.invalid |-> data_s1.days <= 16'd36554)
		else $error("stage 1 day count out of range");

	// Time of day of a valid item is always below one day
	a_tod_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !data_s1.invalid |-> data_s1.tod < 17'd86400)
		else $error("stage 1 time of day out of range");

endmodule

`default_nettype wire

// ===== src/c2s_scale.sv =====
// Second pipeline stage: day count times seconds per day.
`default_nettype none

module c2s_scale (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             vld_s1,
	input  wire c2s_pkg::days_t   data_s1,
	output logic                  ready_up,
	input  wire logic             ready_dn,
	output logic                  vld_s2,
	output c2s_pkg::scaled_t      data_s2
);
	import c2s_pkg::*;

	scaled_t nxt;

	// Constant multiply; product fits 32 bits for any valid date
	always_comb begin
		nxt.day_secs = SECS_W'(data_s1.days) * SECS_PER_DAY;
		nxt.tod      = data_s1.tod;
		nxt.invalid  = data_s1.invalid;
	end

	assign ready_up = !vld_s2 || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ready_up) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && vld_s1) begin
			data_s2 <= nxt;
		end
	end

	// A held item stays put while downstream is blocked
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !ready_dn |=> vld_s2 && $stable(data_s2))
		else $error("stage 2 item changed while blocked");

	// An item moves from stage 1 into stage 2 when stage 2 is empty or passes its item on
	a_move_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && ready_up |=> vld_s2)
		else $error("stage 1 item lost on the way to stage 2");

	// Scaled count of a valid item stays below the seconds in 36525 days
	a_whole_days: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !data_s2.invalid |-> data_s2.day_secs < SECS_LIMIT)
		else $error("stage 2 day seconds out of range");

endmodule

`default_nettype wire

// ===== src/calendar_to_seconds.sv =====
// Top level of the calendar time to seconds-since-2000 converter.
//
// Usage:
//   Input channel in_valid/in_stall carries one calendar time per transfer:
//   year_since_2000, month, day_of_month, hour, minute, second.
//   Output channel out_valid/out_stall carries one result per transfer:
//   seconds_since_2000 and invalid. An out-of-range field gives invalid = 1
//   and zero seconds. Day past the end of its month is not flagged.
//   Each input transfer passes the day count register, the multiply register
//   and the output register, which drives out_valid. Throughput: one transfer
//   per cycle while out_stall is low; three register stages (day count,
//   constant multiply by 86400, final add) each hold one item.
//   When the receiver stalls, the stages fill up behind the output register;
//   in_stall rises only once every stage holds an item, and the output holds
//   its value until taken. Nothing is dropped or repeated.
//   Reset clears all stage valid bits; the pipeline starts empty.
`default_nettype none

module calendar_to_seconds (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [c2s_pkg::YEAR_W-1:0]    year_since_2000,
	input  wire logic [c2s_pkg::MONTH_W-1:0]   month,
	input  wire logic [c2s_pkg::DAY_W-1:0]     day_of_month,
	input  wire logic [c2s_pkg::HOUR_W-1:0]    hour,
	input  wire logic [c2s_pkg::MIN_W-1:0]     minute,
	input  wire logic [c2s_pkg::SEC_W-1:0]     second,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [c2s_pkg::SECS_W-1:0]         seconds_since_2000,
	output logic                               invalid
);
	import c2s_pkg::*;

	logic              ready_s1;
	logic              ready_s2;
	logic              ready_s3;
	logic              vld_s1;
	logic              vld_s2;
	logic              vld_s3;
	days_t             data_s1;
	scaled_t           data_s2;
	logic [SECS_W-1:0] secs_s3;
	logic              invalid_s3;
	logic [SECS_W-1:0] sum;

	c2s_days u_days (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_in        (in_valid),
		.ready_up        (ready_s1),
		.ready_dn        (ready_s2),
		.year_since_2000 (year_since_2000),
		.month           (month),
		.day_of_month    (day_of_month),
		.hour            (hour),
		.minute          (minute),
		.second          (second),
		.vld_s1          (vld_s1),
		.data_s1         (data_s1)
	);

	c2s_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.data_s1  (data_s1),
		.ready_up (ready_s2),
		.ready_dn (ready_s3),
		.vld_s2   (vld_s2),
		.data_s2  (data_s2)
	);

	assign in_stall = !ready_s1;

	// Final add, forced to zero for an invalid transfer
	assign sum = data_s2.invalid ? '0 : (data_s2.day_secs + SECS_W'(data_s2.tod));

	// Output register
	assign ready_s3 = !vld_s3 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ready_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && vld_s2) begin
			secs_s3    <= sum;
			invalid_s3 <= data_s2.invalid;
		end
	end

	assign out_valid          = vld_s3;
	assign seconds_since_2000 = secs_s3;
	assign invalid            = invalid_s3;

	// Invalid results carry zero seconds
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && invalid_s3 |-> secs_s3 == '0)
		else $error("invalid result with nonzero seconds");

	// Valid results stay below the end of 2099
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> secs_s3 < SECS_LIMIT)
		else $error("result beyond end of 2099");

	// Input is never stalled while the first stage is empty
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> !in_stall)
		else $error("input stalled with empty first stage");

	// Input stalls only when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && vld_s2 && vld_s3 && out_stall)
		else $error("input stalled with a free stage");

endmodule

`default_nettype wire
